### src/qph_pkg.sv
// qph_pkg: shared types and codes for the quadratic probe hash table
// request and response payloads, table entry layout, request and status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qph_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_INSERTED     = 3'd0,
    ST_FULL         = 3'd1,
    ST_FOUND        = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_DELETED      = 3'd4,
    ST_NONE_DELETED = 3'd5,
    ST_ZERO_KEY     = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] key;
    logic [15:0] rec_id;
    logic [3:0]  rec_month;
    logic [11:0] rec_year;
    logic [7:0]  rec_score;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [4:0]  deleted_count;
    logic [15:0] out_id;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic [7:0]  out_score;
  } rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] id;
    logic [3:0]  month;
    logic [11:0] year;
    logic [7:0]  score;
  } entry_t;

endpackage

`default_nettype wire

### src/qph_home.sv
// qph_home: home slot of a key, key mod SLOTS
// two constant byte tables and one add with a single wrap correction
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module qph_home #(
  parameter int SLOTS = 16
) (
  input  wire logic [15:0]                key,
  output logic      [$clog2(SLOTS)-1:0]  home
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W:0] SLOTS_X = (IDX_W+1)'(SLOTS);

  logic [IDX_W-1:0] lo_tab [256];
  logic [IDX_W-1:0] hi_tab [256];
  logic [IDX_W:0]   sum;

  // residues of the low byte and of the high byte weighted by 256
  for (genvar j = 0; j < 256; j++) begin : g_tab
    assign lo_tab[j] = IDX_W'(j % SLOTS);
    assign hi_tab[j] = IDX_W'((j * 256) % SLOTS);
  end

  assign sum  = {1'b0, lo_tab[key[7:0]]} + {1'b0, hi_tab[key[15:8]]};
  assign home = (sum >= SLOTS_X) ? IDX_W'(sum - SLOTS_X) : IDX_W'(sum);

endmodule

`default_nettype wire

### src/qph_table.sv
// qph_table: slot memory with registered read and per-slot valid bits
// an invalid slot reads as an all-zero entry, so a zero key means empty
// depends on qph_pkg
`timescale 1ns / 1ps
`default_nettype none

module qph_table #(
  parameter int SLOTS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [$clog2(SLOTS)-1:0]  rd_addr,
  output qph_pkg::entry_t                rd_entry,
  input  wire logic                      wr_en,
  input  wire logic [$clog2(SLOTS)-1:0]  wr_addr,
  input  qph_pkg::entry_t                wr_entry,
  input  wire logic                      clr_en,
  input  wire logic [$clog2(SLOTS)-1:0]  clr_addr
);

  qph_pkg::entry_t mem [SLOTS];
  qph_pkg::entry_t rd_q;
  logic [SLOTS-1:0] valid;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid[clr_addr] <= 1'b0;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_entry = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

### src/quadratic_probe_hash_table.sv
// quadratic_probe_hash_table: open-addressing hash table with quadratic probing
//
// req channel (req_valid/req_ready/req) takes one transaction at a time:
// insert, search or delete by a nonzero key. rsp channel (rsp_valid/rsp_ready/rsp)
// returns exactly one response per request, in order.
// insert and search walk the probe path (home + i*i) mod SLOTS, one slot
// memory read per cycle; insert stops at the first empty slot, search at the
// first matching slot, both at the end of the path. delete reads every slot
// once, in order, and clears each match. a zero key or unused request type
// answers without reading the slot memory.
// req_ready is high whenever no request is in progress; the response sits in
// an output register, so a new request is taken while rsp waits on rsp_ready.
// a stalled receiver only delays the end of the following request.
// reset empties the table at once (per-slot valid bits) and drops any response.
// depends on qph_pkg, qph_home, qph_table
`timescale 1ns / 1ps
`default_nettype none

module quadratic_probe_hash_table #(
  parameter int SLOTS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  qph_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output qph_pkg::rsp_t  rsp
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W:0]   SLOTS_X = (IDX_W+1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_PROBE  = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t state, state_next;

  qph_pkg::req_type_t op;
  logic [15:0]       key_q;
  qph_pkg::entry_t   entry_q;
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  step;
  logic [IDX_W-1:0]  cnt;
  logic              issuing;
  logic              chk_vld;
  logic [IDX_W-1:0]  chk_addr;
  logic              chk_last;
  logic [CNT_W-1:0]  del_cnt;
  qph_pkg::rsp_t     res_q;
  qph_pkg::rsp_t     res_next;
  qph_pkg::rsp_t     imm_res;

  logic [IDX_W-1:0]  home;
  logic [IDX_W:0]    sum_a;
  logic [IDX_W:0]    sum_d;
  logic [IDX_W-1:0]  addr_next;
  logic [IDX_W-1:0]  step_next;
  logic [CNT_W-1:0]  del_total;

  logic              req_fire;
  logic              req_known;
  logic              immediate;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  qph_pkg::entry_t   rd_entry;
  logic              key_eq;
  logic              ins_hit;
  logic              srch_hit;
  logic              del_hit;
  logic              probe_end;
  logic              out_free;

  qph_home #(.SLOTS(SLOTS)) u_home (
    .key  (req.key),
    .home (home)
  );

  qph_table #(.SLOTS(SLOTS)) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (ins_hit),
    .wr_addr  (chk_addr),
    .wr_entry (entry_q),
    .clr_en   (del_hit),
    .clr_addr (chk_addr)
  );

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign req_known = req.req_type inside {qph_pkg::REQ_INSERT, qph_pkg::REQ_SEARCH,
                                          qph_pkg::REQ_DELETE};
  assign immediate = !req_known || (req.key == '0);
  assign out_free  = !rsp_valid || rsp_ready;

  // next probe offset: addr += 2i+1, both kept mod SLOTS
  assign sum_a     = {1'b0, addr} + {1'b0, step};
  assign addr_next = (sum_a >= SLOTS_X) ? IDX_W'(sum_a - SLOTS_X) : IDX_W'(sum_a);
  assign sum_d     = {1'b0, step} + (IDX_W+1)'(2);
  assign step_next = (sum_d >= SLOTS_X) ? IDX_W'(sum_d - SLOTS_X) : IDX_W'(sum_d);

  assign rd_en   = (state == S_PROBE) && issuing;
  assign rd_addr = (op == qph_pkg::REQ_DELETE) ? cnt : addr;

  assign key_eq    = (rd_entry.key == key_q);
  assign ins_hit   = chk_vld && (op == qph_pkg::REQ_INSERT) && (rd_entry.key == '0);
  assign srch_hit  = chk_vld && (op == qph_pkg::REQ_SEARCH) && key_eq;
  assign del_hit   = chk_vld && (op == qph_pkg::REQ_DELETE) && key_eq;
  assign probe_end = ins_hit || srch_hit || (chk_vld && chk_last);
  assign del_total = del_cnt + CNT_W'(del_hit);

  always_comb begin
    imm_res        = '0;
    imm_res.status = req_known ? qph_pkg::ST_ZERO_KEY : qph_pkg::ST_NOT_FOUND;
  end

  always_comb begin
    res_next = '0;
    case (op)
      qph_pkg::REQ_INSERT: begin
        if (ins_hit) begin
          res_next.status = qph_pkg::ST_INSERTED;
          res_next.slot   = 4'(chk_addr);
        end else begin
          res_next.status = qph_pkg::ST_FULL;
        end
      end
      qph_pkg::REQ_SEARCH: begin
        if (srch_hit) begin
          res_next.status    = qph_pkg::ST_FOUND;
          res_next.slot      = 4'(chk_addr);
          res_next.out_id    = rd_entry.id;
          res_next.out_month = rd_entry.month;
          res_next.out_year  = rd_entry.year;
          res_next.out_score = rd_entry.score;
        end else begin
          res_next.status = qph_pkg::ST_NOT_FOUND;
        end
      end
      qph_pkg::REQ_DELETE: begin
        res_next.status        = (del_total != '0) ? qph_pkg::ST_DELETED
                                                   : qph_pkg::ST_NONE_DELETED;
        res_next.deleted_count = 5'(del_total);
      end
      default: begin
        res_next.status = qph_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = immediate ? S_RESULT : S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_end) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issuing   <= 1'b0;
      chk_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        issuing <= req_fire && !immediate;
        chk_vld <= 1'b0;
      end else if (probe_end) begin
        issuing <= 1'b0;
        chk_vld <= 1'b0;
      end else begin
        chk_vld <= rd_en;
        if (rd_en && (cnt == LAST)) begin
          issuing <= 1'b0;
        end
      end
      if (state == S_RESULT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request context, probe walk and result payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op            <= qph_pkg::req_type_t'(req.req_type);
      key_q         <= req.key;
      entry_q.key   <= req.key;
      entry_q.id    <= req.rec_id;
      entry_q.month <= req.rec_month;
      entry_q.year  <= req.rec_year;
      entry_q.score <= req.rec_score;
      addr          <= home;
      step          <= IDX_W'(1);
      cnt           <= '0;
      del_cnt       <= '0;
      res_q         <= imm_res;
    end else if (state == S_PROBE) begin
      if (rd_en) begin
        chk_addr <= rd_addr;
        chk_last <= (cnt == LAST);
        cnt      <= cnt + IDX_W'(1);
        addr     <= addr_next;
        step     <= step_next;
      end
      if (del_hit) begin
        del_cnt <= del_total;
      end
      if (probe_end) begin
        res_q <= res_next;
      end
    end
    if (state == S_RESULT && out_free) begin
      rsp <= res_q;
    end
  end

  a_zero_key: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.key == '0 && req_known) |=>
      (state == S_RESULT && res_q.status == qph_pkg::ST_ZERO_KEY))
    else $error("zero key request did not answer zero key rejected");

  a_ins_empty: assert property (@(posedge clk) disable iff (rst)
    ins_hit |-> (rd_entry.key == '0 && state == S_PROBE))
    else $error("insert wrote a slot that was not empty");

  a_del_match: assert property (@(posedge clk) disable iff (rst)
    del_hit |-> (rd_entry.key == key_q && key_q != '0))
    else $error("delete cleared a slot holding another key");

  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESULT))
    else $error("response raised outside the result state");

endmodule

`default_nettype wire
